/* hdl/copy_number_segment_merger_macros.svh */
// ----------------------------------------------------------------------------
// Copy-number segment merger assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COPY_NUMBER_SEGMENT_MERGER_MACROS_SVH
`define COPY_NUMBER_SEGMENT_MERGER_MACROS_SVH

`ifndef SYNTHESIS
`define CNSM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define CNSM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CNSM_ASSERT(lbl, clk, rstn, prop)
`define CNSM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* hdl/cnsm_pkg.sv */
// ----------------------------------------------------------------------------
// Copy-number segment merger package
// Constants, transaction types and helpers shared by the merger.
// ----------------------------------------------------------------------------
`default_nettype none

package cnsm_pkg;

  localparam int NumSamples = 8;
  localparam int CnWidth    = 8;
  localparam int MaxBins    = 65536;
  localparam int BinW       = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int IdxW       = 16;
  localparam int CountW     = 17;

  localparam logic [BinW-1:0]   BinMax   = BinW'(MaxBins - 1);
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [1:0] ModeMerge   = 2'd0;
  localparam logic [1:0] ModeVarOnly = 2'd1;

  localparam logic [1:0] RegNormal = 2'd0;
  localparam logic [1:0] RegMode   = 2'd1;

  typedef struct packed {
    logic [7:0]  chromosome;
    logic [23:0] position;
    logic [63:0] sample_cns;
    logic        last_bin;
  } bin_t;

  typedef struct packed {
    logic              segment_valid;
    logic [7:0]        seg_chromosome;
    logic [IdxW-1:0]   first_index;
    logic [IdxW-1:0]   last_index;
    logic [23:0]       first_position;
    logic [23:0]       last_position;
    logic [CountW-1:0] invariant_count;
    logic              is_final;
  } res_t;

  typedef struct packed {
    logic            open;
    logic [7:0]      chromosome;
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] last_index;
    logic [23:0]     first_position;
    logic [23:0]     last_position;
    logic [63:0]     cn_vector;
  } seg_t;

  function automatic res_t seg_rec(input seg_t s);
    res_t r;
    r                 = '0;
    r.segment_valid   = 1'b1;
    r.seg_chromosome  = s.chromosome;
    r.first_index     = s.first_index;
    r.last_index      = s.last_index;
    r.first_position  = s.first_position;
    r.last_position   = s.last_position;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/copy_number_segment_merger.sv */
// ----------------------------------------------------------------------------
// Copy-number segment merger
// Classifies genomic bins as variable or invariable; in merge mode it merges runs
// of equal variable bins into segments, in the other modes it emits single-bin segments.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o   | cnsm_pkg::bin_t
//  out     | output    | out_valid_o / out_stall_i | cnsm_pkg::res_t
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One bin per cycle while out_stall_i is low and each bin yields at most one result; a
//  bin that yields two results keeps the two-entry output buffer busy until both leave.
//  A bin is taken when the output buffer is empty after this cycle's transfer.
//  Results are registered and appear in the cycle after the bin is taken.
//  Reset: normal_value 2, merge mode, no open segment, counters zero.
//  out_stall_i holds the buffer head; in_stall_o follows buffer occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "copy_number_segment_merger_macros.svh"

module copy_number_segment_merger (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire cnsm_pkg::bin_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output cnsm_pkg::res_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [7:0]     cfg_data_i
);

  logic [7:0] normal_q;
  logic [1:0] mode_q;

  cnsm_pkg::seg_t open_q, open_d;
  logic [cnsm_pkg::BinW-1:0]   bin_cnt_q, bin_cnt_d;
  logic [cnsm_pkg::CountW-1:0] inv_cnt_q, inv_cnt_d, inv_cnt_inc;

  cnsm_pkg::res_t slot_q [2];
  cnsm_pkg::res_t slot0_d, slot1_d;
  logic [1:0] cnt_q, cnt_d;

  logic [63:0] lanes;
  logic        is_var, cont, accept, pop, has_a, has_b;
  logic [1:0]  n_rem;
  cnsm_pkg::res_t rec_a, rec_b;
  cnsm_pkg::seg_t own_seg;
  logic [cnsm_pkg::IdxW-1:0] idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q <= 8'd2;
      mode_q   <= cnsm_pkg::ModeMerge;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cnsm_pkg::RegNormal) normal_q <= cfg_data_i;
      if (cfg_index_i == cnsm_pkg::RegMode)   mode_q   <= cfg_data_i[1:0];
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign n_rem       = cnt_q - {1'b0, pop};
  assign in_stall_o  = (n_rem != 2'd0);
  assign accept      = in_valid_i && !in_stall_o;
  assign idx         = cnsm_pkg::IdxW'(bin_cnt_q);

  always_comb begin
    lanes  = '0;
    is_var = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i < cnsm_pkg::NumSamples) begin
        lanes[8*i +: cnsm_pkg::CnWidth] = in_data_i.sample_cns[8*i +: cnsm_pkg::CnWidth];
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (i < cnsm_pkg::NumSamples && lanes[8*i +: 8] != normal_q) is_var = 1'b1;
    end
  end

  always_comb begin
    cont = is_var && open_q.open && (open_q.chromosome == in_data_i.chromosome) &&
           (open_q.cn_vector == lanes);

    bin_cnt_d = bin_cnt_q;
    if (bin_cnt_q != cnsm_pkg::BinMax) bin_cnt_d = bin_cnt_q + 1'b1;
    inv_cnt_inc = inv_cnt_q;
    if (!is_var && inv_cnt_q != cnsm_pkg::CountMax) inv_cnt_inc = inv_cnt_q + 1'b1;
    inv_cnt_d = inv_cnt_inc;

    own_seg                = '0;
    own_seg.open           = 1'b1;
    own_seg.chromosome     = in_data_i.chromosome;
    own_seg.first_index    = idx;
    own_seg.last_index     = idx;
    own_seg.first_position = in_data_i.position;
    own_seg.last_position  = in_data_i.position;
    own_seg.cn_vector      = lanes;

    open_d = open_q;
    has_a  = 1'b0;
    has_b  = 1'b0;
    rec_a  = '0;
    rec_b  = '0;

    if (mode_q == cnsm_pkg::ModeMerge) begin
      if (cont) begin
        open_d.last_index    = idx;
        open_d.last_position = in_data_i.position;
      end else begin
        if (open_q.open) begin
          has_a       = 1'b1;
          rec_a       = cnsm_pkg::seg_rec(open_q);
          open_d.open = 1'b0;
        end
        if (is_var) open_d = own_seg;
      end
      if (in_data_i.last_bin) begin
        has_b = 1'b1;
        if (open_d.open) rec_b = cnsm_pkg::seg_rec(open_d);
        rec_b.is_final        = 1'b1;
        rec_b.invariant_count = inv_cnt_inc;
      end
    end else begin
      if (open_q.open) begin
        has_a       = 1'b1;
        rec_a       = cnsm_pkg::seg_rec(open_q);
        open_d.open = 1'b0;
      end
      if (is_var || mode_q != cnsm_pkg::ModeVarOnly) begin
        has_b = 1'b1;
        rec_b = cnsm_pkg::seg_rec(own_seg);
      end else if (in_data_i.last_bin) begin
        has_b = 1'b1;
      end
      if (in_data_i.last_bin) begin
        rec_b.is_final        = 1'b1;
        rec_b.invariant_count = inv_cnt_inc;
      end
    end

    if (in_data_i.last_bin) begin
      open_d    = '0;
      bin_cnt_d = '0;
      inv_cnt_d = '0;
    end
  end

  always_comb begin
    slot0_d = slot_q[0];
    slot1_d = slot_q[1];
    cnt_d   = cnt_q;
    if (accept) begin
      slot0_d = has_a ? rec_a : rec_b;
      slot1_d = rec_b;
      cnt_d   = {1'b0, has_a} + {1'b0, has_b};
    end else if (pop) begin
      slot0_d = slot_q[1];
      cnt_d   = n_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= '0;
      bin_cnt_q <= '0;
      inv_cnt_q <= '0;
      cnt_q     <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        open_q    <= open_d;
        bin_cnt_q <= bin_cnt_d;
        inv_cnt_q <= inv_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot0_d;
    slot_q[1] <= slot1_d;
  end

  `CNSM_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3)
  `CNSM_ASSERT(a_last_gives_result, clk_i, rst_ni,
    accept && in_data_i.last_bin |=> out_valid_o)
  `CNSM_ASSERT(a_last_clears_stream, clk_i, rst_ni,
    accept && in_data_i.last_bin |=> !open_q.open && bin_cnt_q == '0 && inv_cnt_q == '0)
  `CNSM_ASSERT(a_empty_seg_zero, clk_i, rst_ni,
    out_valid_o && !out_data_o.segment_valid |-> out_data_o.first_index == '0 &&
    out_data_o.last_position == '0 && out_data_o.is_final)

endmodule

`default_nettype wire

/* tb/tb_copy_number_segment_merger.sv */
// ----------------------------------------------------------------------------
// Copy-number segment merger testbench
// Streams genomic bins through the merger, predicts every segment and final
// count in a scoreboard, and compares each output transaction field by field.
// Covers all segment modes, normal-value extremes, back-pressure, and random
// gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_copy_number_segment_merger;

  localparam logic [1:0] ModeEvery  = 2'd2;
  localparam logic [1:0] ModeSpare  = 2'd3;
  localparam int         HoldCycles = 400;

  class segment_scoreboard;
    logic [7:0]                  normal_value;
    logic [1:0]                  seg_mode;
    cnsm_pkg::seg_t              open_seg;
    logic [cnsm_pkg::IdxW-1:0]   bin_idx;
    logic [cnsm_pkg::CountW-1:0] invar_cnt;
    cnsm_pkg::res_t              expected_q[$];
    int                          mismatches;
    int                          checked;
    int                          streams;

    function void clear_stream();
      open_seg  = '0;
      bin_idx   = '0;
      invar_cnt = '0;
    endfunction

    function void apply_reset();
      normal_value = 8'd2;
      seg_mode     = cnsm_pkg::ModeMerge;
      clear_stream();
      expected_q.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      if (idx == cnsm_pkg::RegNormal) normal_value = data;
      else if (idx == cnsm_pkg::RegMode) seg_mode = data[1:0];
    endfunction

    function void expect_result(cnsm_pkg::res_t r);
      expected_q = {expected_q, r};
    endfunction

    function cnsm_pkg::res_t segment_of(cnsm_pkg::seg_t s, logic fin);
      cnsm_pkg::res_t r;
      r                 = '0;
      r.segment_valid   = 1'b1;
      r.seg_chromosome  = s.chromosome;
      r.first_index     = s.first_index;
      r.last_index      = s.last_index;
      r.first_position  = s.first_position;
      r.last_position   = s.last_position;
      r.invariant_count = fin ? invar_cnt : '0;
      r.is_final        = fin;
      return r;
    endfunction

    function cnsm_pkg::res_t empty_final();
      cnsm_pkg::res_t r;
      r                 = '0;
      r.invariant_count = invar_cnt;
      r.is_final        = 1'b1;
      return r;
    endfunction

    function void note_bin(cnsm_pkg::bin_t b);
      logic [63:0]               lanes;
      logic                      variable_bin;
      logic [cnsm_pkg::IdxW-1:0] idx;
      cnsm_pkg::seg_t            own;
      lanes        = '0;
      variable_bin = 1'b0;
      idx          = bin_idx;
      for (int i = 0; i < cnsm_pkg::NumSamples; i++) begin
        lanes[8*i +: cnsm_pkg::CnWidth] = b.sample_cns[8*i +: cnsm_pkg::CnWidth];
        if (lanes[8*i +: 8] != normal_value) variable_bin = 1'b1;
      end
      if (!variable_bin && invar_cnt != cnsm_pkg::CountMax) invar_cnt++;
      if (bin_idx != cnsm_pkg::BinMax) bin_idx++;

      own                = '0;
      own.open           = 1'b1;
      own.chromosome     = b.chromosome;
      own.first_index    = idx;
      own.last_index     = idx;
      own.first_position = b.position;
      own.last_position  = b.position;
      own.cn_vector      = lanes;

      if (seg_mode == cnsm_pkg::ModeMerge) begin
        if (variable_bin && open_seg.open && open_seg.chromosome == b.chromosome &&
            open_seg.cn_vector == lanes) begin
          open_seg.last_index    = idx;
          open_seg.last_position = b.position;
        end else begin
          if (open_seg.open) expect_result(segment_of(open_seg, 1'b0));
          open_seg.open = 1'b0;
          if (variable_bin) open_seg = own;
        end
        if (b.last_bin) begin
          if (open_seg.open) expect_result(segment_of(open_seg, 1'b1));
          else expect_result(empty_final());
        end
      end else begin
        // a run left open by merge mode closes ahead of this bin
        if (open_seg.open) expect_result(segment_of(open_seg, 1'b0));
        open_seg.open = 1'b0;
        if (variable_bin || seg_mode != cnsm_pkg::ModeVarOnly)
          expect_result(segment_of(own, b.last_bin));
        else if (b.last_bin)
          expect_result(empty_final());
      end
      if (b.last_bin) begin
        clear_stream();
        streams++;
      end
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(cnsm_pkg::res_t r);
      cnsm_pkg::res_t e;
      if (expected_q.size() == 0) begin
        $error("segment transaction with nothing expected: valid %0b final %0b",
               r.segment_valid, r.is_final);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      check_field("segment_valid", 32'(e.segment_valid), 32'(r.segment_valid));
      check_field("seg_chromosome", 32'(e.seg_chromosome), 32'(r.seg_chromosome));
      check_field("first_index", 32'(e.first_index), 32'(r.first_index));
      check_field("last_index", 32'(e.last_index), 32'(r.last_index));
      check_field("first_position", 32'(e.first_position), 32'(r.first_position));
      check_field("last_position", 32'(e.last_position), 32'(r.last_position));
      check_field("invariant_count", 32'(e.invariant_count), 32'(r.invariant_count));
      check_field("is_final", 32'(e.is_final), 32'(r.is_final));
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  cnsm_pkg::bin_t in_data;
  logic           out_valid;
  logic           out_stall;
  cnsm_pkg::res_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_index;
  logic [7:0]     cfg_data;

  segment_scoreboard sb = new();

  int          rx_hold_req;
  logic        rx_quiet;
  logic        tx_quiet;
  int          bins_sent;
  logic [3:0]  modes_seen;
  logic [7:0]  gen_chr;
  logic [23:0] gen_pos;
  logic [63:0] gen_cns;
  int          stream_left;

  copy_number_segment_merger u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stall per transaction, plus an optional long hold-off
  initial begin
    int k;
    int holds_done;
    out_stall  = 1'b0;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req != holds_done) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        holds_done = rx_hold_req;
      end
      k = rx_quiet ? 0 : $urandom_range(0, 11);
      if (k > 0) begin
        out_stall = 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic cnsm_pkg::bin_t mk(logic [7:0] chr, logic [23:0] pos,
                                        logic [63:0] cns, logic last);
    cnsm_pkg::bin_t b;
    b.chromosome = chr;
    b.position   = pos;
    b.sample_cns = cns;
    b.last_bin   = last;
    return b;
  endfunction

  task automatic send_bin(cnsm_pkg::bin_t b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk); while (in_stall);
    sb.note_bin(b);
    bins_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // bins that produce no transaction may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    if (idx == cnsm_pkg::RegMode) modes_seen[data[1:0]] = 1'b1;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_bin(output cnsm_pkg::bin_t b);
    int          r;
    int          n;
    logic [63:0] normal_vec;
    normal_vec = {8{sb.normal_value}};
    r          = $urandom_range(0, 99);
    gen_pos    = gen_pos + 24'($urandom_range(1, 3));
    if (r < 10) begin
      gen_chr = 8'($urandom);
      gen_pos = 24'($urandom);
      gen_cns = {$urandom, $urandom};
      b = mk(gen_chr, gen_pos, gen_cns, ($urandom_range(0, 49) == 0));
      if (b.last_bin) stream_left = $urandom_range(3, 80);
      return;
    end else if (r < 35) begin
      b = mk(gen_chr, gen_pos, normal_vec, 1'b0);
    end else if (r < 75) begin
      b = mk(gen_chr, gen_pos, gen_cns, 1'b0);
    end else begin
      if (r >= 88) gen_chr = ($urandom_range(0, 1) == 0) ? gen_chr + 8'd1 : 8'($urandom);
      gen_cns = normal_vec;
      n = $urandom_range(1, 3);
      repeat (n) gen_cns[8*$urandom_range(0, 7) +: 8] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(0, 5) == 0) gen_cns = {$urandom, $urandom};
      b = mk(gen_chr, gen_pos, gen_cns, 1'b0);
    end
    stream_left--;
    if (stream_left <= 0) begin
      b.last_bin  = 1'b1;
      stream_left = $urandom_range(3, 80);
    end
  endtask

  initial begin
    cnsm_pkg::bin_t b;
    logic [63:0]    vec_a;
    logic [63:0]    vec_b;
    logic [63:0]    vec_n;
    logic [1:0]     mode;
    logic [7:0]     normal;
    int             waited;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = cnsm_pkg::RegNormal;
    cfg_data    = '0;
    rx_hold_req = 0;
    rx_quiet    = 1'b0;
    tx_quiet    = 1'b0;
    bins_sent   = 0;
    modes_seen  = 4'b0001;
    gen_chr     = 8'd1;
    gen_pos     = '0;
    gen_cns     = '1;
    stream_left = 20;
    sb.apply_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    vec_a = 64'h0102_0304_0506_0708;
    vec_b = '0;
    vec_n = {8{8'h02}};

    // merge mode, normal value 2
    send_bin(mk(8'd0, 24'd0, vec_n, 1'b0));
    send_bin(mk(8'd1, 24'd10, vec_a, 1'b0));
    send_bin(mk(8'd1, 24'd11, vec_a, 1'b0));
    send_bin(mk(8'd1, 24'd12, vec_a, 1'b0));
    send_bin(mk(8'd1, 24'd13, vec_b, 1'b0));
    send_bin(mk(8'd2, 24'd14, vec_b, 1'b0));
    send_bin(mk(8'd255, 24'hFF_FFFF, '1, 1'b0));
    send_bin(mk(8'd255, 24'hFF_FFFF, '1, 1'b0));
    send_bin(mk(8'd255, 24'd0, vec_n, 1'b0));
    send_bin(mk(8'd7, 24'd100, vec_a, 1'b0));
    send_bin(mk(8'd7, 24'd101, vec_a, 1'b1));
    send_bin(mk(8'd0, 24'd0, vec_n, 1'b1));
    send_bin(mk(8'd3, 24'd5, vec_a, 1'b0));
    send_bin(mk(8'd3, 24'd6, vec_b, 1'b1));
    send_bin(mk(8'd3, 24'd7, vec_a, 1'b0));
    // segment left open across a switch to variable-only mode
    wait_drained();
    cfg_write(cnsm_pkg::RegMode, cnsm_pkg::ModeVarOnly);
    send_bin(mk(8'd3, 24'd8, vec_n, 1'b0));
    send_bin(mk(8'd4, 24'd9, vec_a, 1'b0));
    send_bin(mk(8'd4, 24'd10, vec_n, 1'b1));
    send_bin(mk(8'd5, 24'd1, vec_a, 1'b1));
    wait_drained();
    cfg_write(cnsm_pkg::RegMode, ModeEvery);
    send_bin(mk(8'd6, 24'd2, vec_n, 1'b0));
    send_bin(mk(8'd6, 24'd3, vec_a, 1'b1));
    wait_drained();
    cfg_write(cnsm_pkg::RegMode, ModeSpare);
    send_bin(mk(8'd6, 24'd4, vec_n, 1'b0));
    send_bin(mk(8'd6, 24'd5, vec_b, 1'b1));
    wait_drained();
    cfg_write(cnsm_pkg::RegNormal, 8'd255);
    cfg_write(cnsm_pkg::RegMode, cnsm_pkg::ModeMerge);
    send_bin(mk(8'd1, 24'd1, '1, 1'b0));
    send_bin(mk(8'd1, 24'd2, vec_n, 1'b1));

    // random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      unique case (p)
        0:       begin mode = cnsm_pkg::ModeMerge;   normal = 8'd2;   end
        1:       begin mode = cnsm_pkg::ModeVarOnly; normal = 8'd0;   end
        2:       begin mode = ModeEvery;             normal = 8'd255; end
        3:       begin mode = ModeSpare;             normal = 8'd4;   end
        4:       begin mode = cnsm_pkg::ModeMerge;   normal = 8'd255; end
        5:       begin mode = cnsm_pkg::ModeMerge;   normal = 8'd0;   end
        default: begin mode = 2'($urandom_range(0, 3)); normal = 8'($urandom); end
      endcase
      cfg_write(cnsm_pkg::RegNormal, normal);
      cfg_write(cnsm_pkg::RegMode, mode);
      tx_quiet = (p == 5);
      rx_quiet = (p == 5);
      // long receiver hold-off while the sender keeps offering bins
      if (p == 2 || p == 4) rx_hold_req++;
      for (int j = 0; j < 150; j++) begin
        if ((p == 2 || p == 4) && j < 60) tx_quiet = 1'b1;
        else if (p != 5 && j % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        if (p != 5 && j % 50 == 25) rx_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 49) == 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        random_bin(b);
        send_bin(b);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    waited   = 0;
    while (sb.expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected segment transactions never arrived", sb.expected_q.size());
      sb.mismatches++;
    end

    $display("Merger run: %0d bins in %0d streams, %0d result transactions compared",
             bins_sent, sb.streams, sb.checked);
    $display("Modes exercised mask %04b, incl. long receiver hold-off and back-pressure",
             modes_seen);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
